// ----- src/sdpm_pkg.sv -----
// ----------------------------------------------------------------------------
// sdpm_pkg
// Shared types, constants and the restoring divide step for the sketch
// dodge pixel map.
// ----------------------------------------------------------------------------
package sdpm_pkg;

  // Field widths and table geometry
  localparam int unsigned LumaW      = 8;
  localparam int unsigned TableDepth = 256;
  localparam int unsigned TableAddrW = $clog2(TableDepth);
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 8;
  localparam int unsigned QueueDepth = 4;

  // Arithmetic constants
  localparam logic [LumaW-1:0] LumaMax = 8'd255;
  localparam int unsigned ContrastRound = 50;
  localparam int unsigned ContrastDiv   = 100;
  localparam int unsigned RecipShift    = 22;
  // ceil(2^22 / 100): exact floor division for magnitudes below 2^22 / 100
  localparam int unsigned ContrastRecipI = ((2 ** RecipShift) + ContrastDiv - 1) / ContrastDiv;
  localparam logic [15:0] ContrastRecip  = 16'(ContrastRecipI);

  // Item kinds
  typedef enum logic {
    MODE_PIXEL       = 1'b0,
    MODE_TABLE_WRITE = 1'b1
  } item_mode_t;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_POSTERIZE_LEVELS = 2'd0,
    REG_CONTRAST_PERCENT = 2'd1
  } cfg_reg_t;

  // Classified item held in the queue between front and back
  typedef struct packed {
    logic                  wr;    // gamma table write
    logic                  sat;   // dodge quotient saturates at full scale
    logic [2*LumaW-1:0]    num;   // original luma times 255
    logic [LumaW-1:0]      den;   // 255 minus blurred inverse
    logic [TableAddrW-1:0] tidx;
    logic [LumaW-1:0]      tval;
  } sdpm_item_t;

  // Settings handed from the register block to the datapath
  typedef struct packed {
    logic             post_en;
    logic [LumaW-1:0] post_factor;
    logic             con_en;
    logic [LumaW-1:0] contrast;
  } sdpm_cfg_t;

  // One restoring division step
  typedef struct packed {
    logic             q;
    logic [LumaW-1:0] rem;
  } div_step_t;

  // Shift one numerator bit into the partial remainder and subtract if it fits.
  // Needs rem < den on entry, so the trial value stays below 2*den.
  function automatic div_step_t div_step(input logic [LumaW-1:0] rem,
                                         input logic             nbit,
                                         input logic [LumaW-1:0] den);
    logic [LumaW:0] trial;
    div_step_t      res;
    trial = {rem, nbit};
    if (trial >= {1'b0, den}) begin
      res.q   = 1'b1;
      res.rem = LumaW'(trial - {1'b0, den});
    end else begin
      res.q   = 1'b0;
      res.rem = trial[LumaW-1:0];
    end
    return res;
  endfunction

endpackage

// ----- src/sketch_dodge_pixel_map_core.sv -----
// ----------------------------------------------------------------------------
// sketch_dodge_pixel_map_core
// A pixel passes the queue, then the 11-stage datapath, which advances as a whole.
// Throughput: one beat per cycle unless out_stall or a level divide holds it.
// After a posterize_levels write, cfg_ready and input are held while the
// posterize step is divided out one bit a cycle.
// Reset (rst_n low, synchronous) empties queue and pipeline and clears the
// registers; the gamma table holds no defined value until written.
// ----------------------------------------------------------------------------
module sketch_dodge_pixel_map_core #(
  parameter int unsigned QUEUE_DEPTH = sdpm_pkg::QueueDepth
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_mode,
  input  logic [sdpm_pkg::LumaW-1:0]      in_original_luma,
  input  logic [sdpm_pkg::LumaW-1:0]      in_blurred_inverse,
  input  logic [sdpm_pkg::TableAddrW-1:0] in_table_index,
  input  logic [sdpm_pkg::LumaW-1:0]      in_table_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [sdpm_pkg::LumaW-1:0]      out_sketch_luma,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sdpm_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [sdpm_pkg::CfgDataW-1:0]   cfg_data
);
  import sdpm_pkg::*;

  sdpm_item_t head;
  logic       head_valid;
  logic       pop;
  logic       cfg_busy;
  sdpm_cfg_t  cfg;

  // Register block
  sdpm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .busy      (cfg_busy),
    .cfg       (cfg)
  );

  // Accept, classify and queue
  sdpm_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_mode            (in_mode),
    .in_original_luma   (in_original_luma),
    .in_blurred_inverse (in_blurred_inverse),
    .in_table_index     (in_table_index),
    .in_table_value     (in_table_value),
    .hold               (cfg_busy),
    .pop                (pop),
    .head_valid         (head_valid),
    .head               (head)
  );

  // Pixel datapath and gamma table
  sdpm_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head            (head),
    .pop             (pop),
    .cfg             (cfg),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sketch_luma (out_sketch_luma)
  );

endmodule

// ----- src/sdpm_ram.sv -----
// ----------------------------------------------------------------------------
// sdpm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sdpm_ram #(
  parameter int unsigned WIDTH = sdpm_pkg::LumaW,
  parameter int unsigned DEPTH = sdpm_pkg::TableDepth
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/sdpm_front.sv -----
// ----------------------------------------------------------------------------
// sdpm_front
// Input side: accepts beats, classifies them as table write or pixel,
// prepares the dodge operands and queues them for the datapath.
// ----------------------------------------------------------------------------
module sdpm_front #(
  parameter int unsigned QUEUE_DEPTH = sdpm_pkg::QueueDepth
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_mode,
  input  logic [sdpm_pkg::LumaW-1:0]   in_original_luma,
  input  logic [sdpm_pkg::LumaW-1:0]   in_blurred_inverse,
  input  logic [sdpm_pkg::TableAddrW-1:0] in_table_index,
  input  logic [sdpm_pkg::LumaW-1:0]   in_table_value,
  input  logic                         hold,
  input  logic                         pop,
  output logic                         head_valid,
  output sdpm_pkg::sdpm_item_t         head
);
  import sdpm_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  sdpm_item_t      q_mem_r [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            full;
  logic            push;
  sdpm_item_t      item;

  // Flow control
  assign full     = (count_r == CntW'(QUEUE_DEPTH));
  assign in_stall = full | hold;
  assign push     = in_valid & ~in_stall;

  // Classify the beat; orig*255 as a shift and subtract, saturation when
  // the quotient would reach 256 or more (always so for a full blur)
  always_comb begin
    item.wr   = (item_mode_t'(in_mode) == MODE_TABLE_WRITE);
    item.num  = {in_original_luma, {LumaW{1'b0}}} - {{LumaW{1'b0}}, in_original_luma};
    item.den  = ~in_blurred_inverse;
    item.sat  = (item.num >= {item.den, {LumaW{1'b0}}});
    item.tidx = in_table_index;
    item.tval = in_table_value;
  end

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CntW'(push) - CntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= item;
    end
  end

  assign head_valid = (count_r != '0);
  assign head       = q_mem_r[rd_ptr_r];

endmodule

// ----- src/sdpm_cfg.sv -----
// ----------------------------------------------------------------------------
// sdpm_cfg
// Configuration registers. A posterize level write starts a bit-serial
// divide of 256 by the level count to get the posterize step.
// ----------------------------------------------------------------------------
module sdpm_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sdpm_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [sdpm_pkg::CfgDataW-1:0] cfg_data,
  output logic                          busy,
  output sdpm_pkg::sdpm_cfg_t           cfg
);
  import sdpm_pkg::*;

  // 256 has LumaW+1 bits, one divide step per cycle
  localparam int unsigned FacSteps = LumaW + 1;
  localparam int unsigned StepW    = $clog2(FacSteps);

  logic [LumaW-1:0] levels_r;
  logic [LumaW-1:0] contrast_r;
  logic [LumaW-1:0] fac_rem_r;
  logic [LumaW-1:0] fac_quo_r;
  logic [StepW-1:0] step_r;
  logic             busy_r;
  logic             wr_en;
  div_step_t        st;

  assign wr_en     = cfg_valid & cfg_ready;
  assign cfg_ready = ~busy_r;
  assign busy      = busy_r;

  // Numerator 256 enters MSB first: a one, then zeros
  assign st = div_step(fac_rem_r, (step_r == '0), levels_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      levels_r   <= '0;
      contrast_r <= '0;
      fac_rem_r  <= '0;
      fac_quo_r  <= '0;
      step_r     <= '0;
      busy_r     <= 1'b0;
    end else if (busy_r) begin
      fac_rem_r <= st.rem;
      fac_quo_r <= {fac_quo_r[LumaW-2:0], st.q};
      step_r    <= step_r + 1'b1;
      if (step_r == StepW'(FacSteps - 1)) begin
        busy_r <= 1'b0;
      end
    end else if (wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_POSTERIZE_LEVELS: begin
          levels_r  <= cfg_data;
          fac_rem_r <= '0;
          fac_quo_r <= '0;
          step_r    <= '0;
          busy_r    <= 1'b1;
        end
        REG_CONTRAST_PERCENT: begin
          contrast_r <= cfg_data;
        end
        default: begin
          // unmapped index, ignored
        end
      endcase
    end
  end

  // Settings seen by the datapath
  always_comb begin
    cfg.post_en     = (levels_r > LumaW'(1));
    cfg.post_factor = fac_quo_r;
    cfg.con_en      = (contrast_r != '0);
    cfg.contrast    = contrast_r;
  end

endmodule

// ----- src/sdpm_back.sv -----
// ----------------------------------------------------------------------------
// sdpm_back
// Datapath: pipelined dodge divide, pipelined posterize remainder,
// contrast multiply with reciprocal divide, gamma table lookup.
// ----------------------------------------------------------------------------
module sdpm_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         head_valid,
  input  sdpm_pkg::sdpm_item_t         head,
  output logic                         pop,
  input  sdpm_pkg::sdpm_cfg_t          cfg,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [sdpm_pkg::LumaW-1:0]   out_sketch_luma
);
  import sdpm_pkg::*;

  localparam int unsigned StepsPerStage = 2;
  localparam int unsigned DodStages     = LumaW / StepsPerStage;
  localparam int unsigned PstStages     = LumaW / StepsPerStage;
  localparam int unsigned MulW          = 2 * (LumaW + 1);
  localparam int unsigned MagW          = 15;
  localparam int unsigned Prod2W        = MagW + 16;
  localparam int unsigned QuoW          = Prod2W - RecipShift;
  localparam int unsigned SumW          = QuoW + 1;

  // Fields that ride along with every beat
  typedef struct packed {
    logic                  wr;
    logic [TableAddrW-1:0] tidx;
    logic [LumaW-1:0]      tval;
  } pass_t;

  typedef struct packed {
    pass_t            p;
    logic             sat;
    logic [LumaW-1:0] sh;
    logic [LumaW-1:0] den;
    logic [LumaW-1:0] rem;
    logic [LumaW-1:0] quo;
  } dod_t;

  typedef struct packed {
    pass_t            p;
    logic [LumaW-1:0] val;
    logic [LumaW-1:0] sh;
    logic [LumaW-1:0] rem;
  } pst_t;

  typedef struct packed {
    pass_t            p;
    logic [LumaW-1:0] val;
    logic [MulW-1:0]  prod;
  } con0_t;

  typedef struct packed {
    pass_t             p;
    logic [LumaW-1:0]  val;
    logic              neg;
    logic [Prod2W-1:0] prod;
  } con1_t;

  logic                 en;
  dod_t                 dod_src [DodStages+1];
  dod_t                 dod_nxt [DodStages];
  dod_t                 dod_r   [DodStages];
  logic [DodStages-1:0] dod_v_r;
  pst_t                 pst_src [PstStages+1];
  pst_t                 pst_nxt [PstStages];
  pst_t                 pst_r   [PstStages];
  logic [PstStages-1:0] pst_v_r;
  con0_t                con0_nxt, con0_r;
  logic                 con0_v_r;
  con1_t                con1_nxt, con1_r;
  logic                 con1_v_r;
  logic                 out_valid_r;
  logic [LumaW-1:0]     post_val;
  logic signed [LumaW:0]  mid_off;
  logic signed [LumaW:0]  gain;
  logic signed [MulW-1:0] biased;
  logic [MulW-1:0]        mag;
  logic [QuoW-1:0]        quo;
  logic signed [SumW-1:0] stretched;
  logic [LumaW-1:0]       con_val;
  logic [TableAddrW-1:0]  rd_addr;
  logic                   tbl_we;
  div_step_t              dst;
  div_step_t              pstp;

  // Whole pipeline advances unless a result is held at the output
  assign en  = ~(out_valid_r & out_stall);
  assign pop = en & head_valid;

  // Dodge divide, two quotient bits per stage
  always_comb begin
    dod_src[0].p.wr   = head.wr;
    dod_src[0].p.tidx = head.tidx;
    dod_src[0].p.tval = head.tval;
    dod_src[0].sat    = head.sat;
    dod_src[0].sh     = head.num[LumaW-1:0];
    dod_src[0].den    = head.den;
    dod_src[0].rem    = head.num[2*LumaW-1:LumaW];
    dod_src[0].quo    = '0;
    for (int k = 0; k < DodStages; k++) begin
      dod_src[k+1] = dod_r[k];
    end
    dst = '0;
    for (int k = 0; k < DodStages; k++) begin
      dod_nxt[k] = dod_src[k];
      for (int j = 0; j < StepsPerStage; j++) begin
        dst            = div_step(dod_nxt[k].rem, dod_nxt[k].sh[LumaW-1], dod_nxt[k].den);
        dod_nxt[k].rem = dst.rem;
        dod_nxt[k].quo = {dod_nxt[k].quo[LumaW-2:0], dst.q};
        dod_nxt[k].sh  = {dod_nxt[k].sh[LumaW-2:0], 1'b0};
      end
    end
  end

  // Posterize remainder by the configured step, two bits per stage
  always_comb begin
    pst_src[0].p   = dod_r[DodStages-1].p;
    pst_src[0].val = dod_r[DodStages-1].sat ? LumaMax : dod_r[DodStages-1].quo;
    pst_src[0].sh  = pst_src[0].val;
    pst_src[0].rem = '0;
    for (int k = 0; k < PstStages; k++) begin
      pst_src[k+1] = pst_r[k];
    end
    pstp = '0;
    for (int k = 0; k < PstStages; k++) begin
      pst_nxt[k] = pst_src[k];
      for (int j = 0; j < StepsPerStage; j++) begin
        pstp           = div_step(pst_nxt[k].rem, pst_nxt[k].sh[LumaW-1], cfg.post_factor);
        pst_nxt[k].rem = pstp.rem;
        pst_nxt[k].sh  = {pst_nxt[k].sh[LumaW-2:0], 1'b0};
      end
    end
  end

  // Posterized value, then offset from mid grey times the gain
  always_comb begin
    post_val = cfg.post_en ? (pst_src[PstStages].val - pst_src[PstStages].rem)
                           : pst_src[PstStages].val;
    mid_off  = $signed({1'b0, post_val}) - $signed({2'b01, {(LumaW-1){1'b0}}});
    gain     = $signed({1'b0, cfg.contrast});
    con0_nxt.p    = pst_src[PstStages].p;
    con0_nxt.val  = post_val;
    con0_nxt.prod = MulW'(mid_off * gain);
  end

  // Round, take magnitude and divide by 100 through the reciprocal
  always_comb begin
    biased        = $signed(con0_r.prod) + $signed(MulW'(ContrastRound));
    mag           = biased[MulW-1] ? MulW'(-biased) : MulW'(biased);
    con1_nxt.p    = con0_r.p;
    con1_nxt.val  = con0_r.val;
    con1_nxt.neg  = biased[MulW-1];
    con1_nxt.prod = Prod2W'(mag[MagW-1:0]) * Prod2W'(ContrastRecip);
  end

  // Quotient back around mid grey, clamped; selects the table address
  always_comb begin
    quo       = con1_r.prod[Prod2W-1:RecipShift];
    stretched = con1_r.neg ? $signed(SumW'(2 ** (LumaW - 1))) - $signed({1'b0, quo})
                           : $signed(SumW'(2 ** (LumaW - 1))) + $signed({1'b0, quo});
    if (stretched < 0) begin
      con_val = '0;
    end else if (stretched > $signed(SumW'(LumaMax))) begin
      con_val = LumaMax;
    end else begin
      con_val = stretched[LumaW-1:0];
    end
    rd_addr = cfg.con_en ? con_val : con1_r.val;
  end

  assign tbl_we = en & con1_v_r & con1_r.p.wr;

  // Stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DodStages; k++) begin
        dod_r[k] <= dod_nxt[k];
      end
      for (int k = 0; k < PstStages; k++) begin
        pst_r[k] <= pst_nxt[k];
      end
      con0_r <= con0_nxt;
      con1_r <= con1_nxt;
    end
  end

  // Stage valid bits; table writes end at the RAM and give no result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dod_v_r     <= '0;
      pst_v_r     <= '0;
      con0_v_r    <= 1'b0;
      con1_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      dod_v_r     <= {dod_v_r[DodStages-2:0], head_valid};
      pst_v_r     <= {pst_v_r[PstStages-2:0], dod_v_r[DodStages-1]};
      con0_v_r    <= pst_v_r[PstStages-1];
      con1_v_r    <= con0_v_r;
      out_valid_r <= con1_v_r & ~con1_r.p.wr;
    end
  end

  // Gamma table; its read register is the output register
  sdpm_ram #(
    .WIDTH (LumaW),
    .DEPTH (TableDepth)
  ) u_gamma_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (con1_r.p.tidx),
    .wdata (con1_r.p.tval),
    .re    (en),
    .raddr (rd_addr),
    .rdata (out_sketch_luma)
  );

  assign out_valid = out_valid_r;

endmodule

// ----- src/sdpm_checker.sv -----
// ----------------------------------------------------------------------------
// sdpm_checker
// Port-level checks on the sketch dodge pixel map, bound to the top level.
// ----------------------------------------------------------------------------
module sdpm_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [sdpm_pkg::LumaW-1:0]      out_sketch_luma,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [sdpm_pkg::CfgIdxW-1:0]    cfg_index
);
  import sdpm_pkg::*;

  // A held result beat keeps its data
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sketch_luma))
    else $error("result beat changed while stalled");

  // Reset empties the output and frees the register port
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && cfg_ready)
    else $error("output or config port not idle after reset");

  // A level write blocks both the register port and the input
  a_level_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready && (cfg_index == REG_POSTERIZE_LEVELS)
      |=> !cfg_ready && in_stall)
    else $error("posterize step divide not holding the ports");

  // Input is held whenever the register port is busy
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_ready |-> in_stall)
    else $error("input taken while posterize step is being computed");

  // The step divide does not free the register port straight after taking it
  a_busy_len: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(cfg_ready) |=> !cfg_ready)
    else $error("posterize step divide ended early");

endmodule

bind sketch_dodge_pixel_map_core sdpm_checker u_checker (.*);

// ----- dv/sketch_dodge_pixel_map_core_tb.sv -----
// ----------------------------------------------------------------------------
// sketch_dodge_pixel_map_core_tb
// Self-checking bench for the sketch dodge pixel map. A gamma curve is loaded
// into the table first, so every later pixel reads a written entry. Directed
// corner beats come next, then random traffic over a series of posterize and
// contrast settings. A scoreboard model predicts every mapped luma at input
// acceptance, and each output beat is checked in order against it.
// ----------------------------------------------------------------------------
module sketch_dodge_pixel_map_core_tb;
  import sdpm_pkg::*;

  localparam int unsigned Latency    = 11;
  localparam int unsigned CycleLimit = 400000;
  // register indexes past the two real ones, expected to be ignored
  localparam logic [CfgIdxW-1:0] RegSpare2 = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSpare3 = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_mode = MODE_PIXEL;
  logic [LumaW-1:0]      in_original_luma = '0;
  logic [LumaW-1:0]      in_blurred_inverse = '0;
  logic [TableAddrW-1:0] in_table_index = '0;
  logic [LumaW-1:0]      in_table_value = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [LumaW-1:0]      out_sketch_luma;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CfgIdxW-1:0]    cfg_index = '0;
  logic [CfgDataW-1:0]   cfg_data = '0;

  // scoreboard state: register copy, gamma table copy, pending luma
  logic [LumaW-1:0] levels_set = '0;
  logic [LumaW-1:0] contrast_set = '0;
  logic [LumaW-1:0] gamma_shadow [TableDepth];
  logic [LumaW-1:0] sketch_luma_expect_q [$];

  int unsigned in_idle_max = 0;
  int unsigned out_idle_max = 0;
  int unsigned error_count = 0;
  int unsigned beats_in = 0;
  int unsigned pixels_checked = 0;
  int unsigned settings_run = 0;
  int unsigned cycle_count = 0;

  sketch_dodge_pixel_map_core DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_mode            (in_mode),
    .in_original_luma   (in_original_luma),
    .in_blurred_inverse (in_blurred_inverse),
    .in_table_index     (in_table_index),
    .in_table_value     (in_table_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_sketch_luma    (out_sketch_luma),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               sketch_luma_expect_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Table index produced by dodge, posterize and contrast
  function automatic logic [LumaW-1:0] predict_gamma_index(input logic [LumaW-1:0] orig,
                                                           input logic [LumaW-1:0] blur);
    int unsigned o;
    int unsigned b;
    int unsigned q;
    int unsigned factor;
    int          m;
    int          r;
    o = orig;
    b = blur;
    // dodge, full scale when the blurred value is white
    if (b == 255) q = 255;
    else q = (o * 255) / (255 - b);
    if (q > 255) q = 255;
    // posterize
    if (levels_set > 1) begin
      factor = 256 / int'(levels_set);
      if (factor < 1) factor = 1;
      q = q - (q % factor);
    end
    // contrast about mid grey, signed divide truncates toward zero
    if (contrast_set != 0) begin
      m = int'(q) - 128;
      r = (m * int'(contrast_set) + 50) / 100 + 128;
      if (r < 0) r = 0;
      if (r > 255) r = 255;
      q = r;
    end
    return LumaW'(q);
  endfunction

  task automatic report_mismatch(input string what, input logic [LumaW-1:0] want,
                                 input logic [LumaW-1:0] got);
    $display("mismatch at cycle %0d: %s, expected %0d, got %0d", cycle_count, what,
             want, got);
    error_count++;
  endtask

  // Send one beat after a random gap, update the scoreboard on acceptance
  task automatic send_beat(input item_mode_t mode, input logic [LumaW-1:0] orig,
                           input logic [LumaW-1:0] blur,
                           input logic [TableAddrW-1:0] idx,
                           input logic [LumaW-1:0] val);
    int unsigned gap;
    gap = $urandom_range(0, in_idle_max);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid           <= 1'b1;
    in_mode            <= mode;
    in_original_luma   <= orig;
    in_blurred_inverse <= blur;
    in_table_index     <= idx;
    in_table_value     <= val;
    do @(posedge clk); while (in_stall);
    beats_in++;
    if (mode == MODE_TABLE_WRITE) gamma_shadow[idx] = val;
    else sketch_luma_expect_q.push_back(gamma_shadow[predict_gamma_index(orig, blur)]);
  endtask

  // Drop valid, wait for every result, then let table writes settle
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sketch_luma_expect_q.size() != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_POSTERIZE_LEVELS: levels_set = data;
      REG_CONTRAST_PERCENT: contrast_set = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly pixels, some table writes; ignored fields always random
  task automatic random_traffic(input int unsigned count);
    int unsigned      kind;
    logic [LumaW-1:0] blur;
    logic [LumaW-1:0] orig;
    for (int unsigned n = 0; n < count; n++) begin
      kind = $urandom_range(0, 9);
      blur = LumaW'($urandom_range(0, 255));
      if (kind == 9) blur = 8'd255;
      // for half the beats keep orig at most 255 - blur, so the quotient fits unless blur is white
      if (kind < 5) orig = LumaW'($urandom_range(0, 255));
      else orig = LumaW'($urandom_range(0, 255 - int'(blur)));
      if (kind == 0)
        send_beat(MODE_TABLE_WRITE, orig, blur, TableAddrW'($urandom_range(0, 255)),
                  LumaW'($urandom_range(0, 255)));
      else
        send_beat(MODE_PIXEL, orig, blur, TableAddrW'($urandom_range(0, 255)),
                  LumaW'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_setting(input logic [LumaW-1:0] levels, input logic [LumaW-1:0] contrast,
                             input int unsigned count, input int unsigned in_max,
                             input int unsigned out_max);
    wait_idle();
    cfg_write(REG_POSTERIZE_LEVELS, levels);
    cfg_write(REG_CONTRAST_PERCENT, contrast);
    in_idle_max  = in_max;
    out_idle_max = out_max;
    settings_run++;
    random_traffic(count);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Whole table loaded with a gamma curve, as the host would
  task automatic load_gamma_table();
    real         expo;
    real         r;
    int unsigned v;
    expo = $urandom_range(400, 2500) / 1000.0;
    in_idle_max  = 3;
    out_idle_max = 3;
    for (int i = 0; i < TableDepth; i++) begin
      r = 255.0 * ((i / 255.0) ** expo);
      v = $rtoi(r + 0.5);
      if (v > 255) v = 255;
      send_beat(MODE_TABLE_WRITE, LumaW'($urandom_range(0, 255)),
                LumaW'($urandom_range(0, 255)), TableAddrW'(i), LumaW'(v));
    end
  endtask

  // Dodge corners at reset settings, back to back
  task automatic test_dodge_extremes();
    in_idle_max  = 0;
    out_idle_max = 0;
    send_beat(MODE_PIXEL, 8'd0, 8'd0, '0, '0);
    send_beat(MODE_PIXEL, 8'd255, 8'd0, '0, '0);
    send_beat(MODE_PIXEL, 8'd0, 8'd255, '0, '0);     // white blur saturates
    send_beat(MODE_PIXEL, 8'd255, 8'd255, '0, '0);
    send_beat(MODE_PIXEL, 8'd1, 8'd254, '0, '0);     // quotient just reaches full scale
    send_beat(MODE_PIXEL, 8'd100, 8'd128, '0, '0);
    send_beat(MODE_PIXEL, 8'd127, 8'd128, '0, '0);   // exactly full scale
    send_beat(MODE_PIXEL, 8'd63, 8'd191, '0, '0);
    send_beat(MODE_PIXEL, 8'd200, 8'd55, '0, '0);
    send_beat(MODE_PIXEL, 8'd128, 8'd0, '0, '0);
    send_beat(MODE_PIXEL, 8'd170, 8'd85, '0, '0);
  endtask

  // Table writes read back at once; the fields of the other kind are ignored
  task automatic test_table_bypass();
    in_idle_max  = 0;
    out_idle_max = 2;
    send_beat(MODE_PIXEL, 8'd77, 8'd33, 8'hFF, 8'hFF);
    send_beat(MODE_TABLE_WRITE, 8'hFF, 8'hFF, 8'd255, 8'h5A);
    send_beat(MODE_PIXEL, 8'd0, 8'd255, 8'd0, 8'd0);
    send_beat(MODE_TABLE_WRITE, 8'hFF, 8'hFF, 8'd0, 8'hA5);
    send_beat(MODE_PIXEL, 8'd0, 8'd0, 8'hFF, 8'hFF);
    send_beat(MODE_TABLE_WRITE, 8'd0, 8'd0, 8'd0, 8'h00);
    send_beat(MODE_TABLE_WRITE, 8'd0, 8'd0, 8'd255, 8'hFF);
    send_beat(MODE_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0);
    send_beat(MODE_PIXEL, 8'd3, 8'd255, 8'd0, 8'd0);
  endtask

  // Register extremes and mid values, with changing pressure on both sides
  task automatic test_register_settings();
    run_setting(8'd0, 8'd0, 150, 15, 15);
    run_setting(8'd1, 8'd0, 130, 0, 0);
    run_setting(8'd255, 8'd255, 150, 0, 15);
    run_setting(8'd2, 8'd100, 150, 15, 0);
    run_setting(8'd3, 8'd37, 150, 15, 15);
    run_setting(8'd0, 8'd255, 150, 0, 0);
    run_setting(8'd255, 8'd0, 130, 7, 7);
    run_setting(8'd128, 8'd1, 130, 15, 15);
    run_setting(LumaW'($urandom_range(2, 254)), LumaW'($urandom_range(1, 254)), 150, 3, 15);
    run_setting(LumaW'($urandom_range(0, 255)), LumaW'($urandom_range(0, 255)), 150, 15, 3);
  endtask

  // Writes to indexes past the register list must change nothing
  task automatic test_spare_index();
    run_setting(8'd4, 8'd150, 40, 5, 5);
    wait_idle();
    cfg_write(RegSpare2, 8'hFF);
    cfg_write(RegSpare3, 8'h00);
    cfg_write(RegSpare2, 8'h00);
    cfg_write(RegSpare3, 8'hFF);
    random_traffic(80);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stall, in-order check
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned      stall_left;
    logic [LumaW-1:0] want;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (sketch_luma_expect_q.size() == 0) begin
          report_mismatch("result with nothing pending", '0, out_sketch_luma);
        end else begin
          want = sketch_luma_expect_q.pop_front();
          if (out_sketch_luma !== want) report_mismatch("sketch_luma", want, out_sketch_luma);
          pixels_checked++;
        end
        stall_left = $urandom_range(0, out_idle_max);
      end
      @(negedge clk);
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    foreach (gamma_shadow[i]) gamma_shadow[i] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    load_gamma_table();
    test_dodge_extremes();
    test_table_bypass();
    test_register_settings();
    test_spare_index();

    wait_idle();
    $display("run covered %0d input beats and %0d checked pixels", beats_in, pixels_checked);
    $display("over %0d posterize/contrast settings plus spare index writes", settings_run);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
